>>> hw/rtl/qrpd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrpd_pkg
// Types and constants shared by the rate PD controller and motor mixer.
// ----------------------------------------------------------------------------
package qrpd_pkg;

  localparam int unsigned RateW  = 16;
  localparam int unsigned ErrW   = RateW + 1;
  localparam int unsigned DiffW  = RateW + 2;
  localparam int unsigned GainW  = 16;
  localparam int unsigned LimW   = 10;
  localparam int unsigned PulseW = 12;
  localparam int unsigned CmdW   = LimW + 1;
  localparam int unsigned FracW  = 12;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned PipeDepth = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgGainPPitchRoll = 3'd0,
    CfgGainDPitchRoll = 3'd1,
    CfgGainPYaw       = 3'd2,
    CfgGainDYaw       = 3'd3,
    CfgAxisLimit      = 3'd4,
    CfgPulseMin       = 3'd5,
    CfgPulseMax       = 3'd6
  } cfg_reg_e;

  localparam logic [GainW-1:0]  RstGainPPitchRoll = 16'd512;
  localparam logic [GainW-1:0]  RstGainDPitchRoll = 16'd4608;
  localparam logic [GainW-1:0]  RstGainPYaw       = 16'd1024;
  localparam logic [GainW-1:0]  RstGainDYaw       = 16'd0;
  localparam logic [LimW-1:0]   RstAxisLimit      = 10'd300;
  localparam logic [PulseW-1:0] RstPulseMin       = 12'd1100;
  localparam logic [PulseW-1:0] RstPulseMax       = 12'd2000;

  typedef struct packed {
    logic signed [RateW-1:0] pitch_rate_target;
    logic signed [RateW-1:0] roll_rate_target;
    logic signed [RateW-1:0] yaw_rate_target;
    logic signed [RateW-1:0] pitch_rate_measured;
    logic signed [RateW-1:0] roll_rate_measured;
    logic signed [RateW-1:0] yaw_rate_measured;
    logic [PulseW-1:0]       throttle_pulse;
  } in_item_t;

  typedef struct packed {
    logic [PulseW-1:0] motor_front_pulse;
    logic [PulseW-1:0] motor_second_pulse;
    logic [PulseW-1:0] motor_third_pulse;
    logic [PulseW-1:0] motor_fourth_pulse;
  } out_item_t;

  typedef struct packed {
    logic [GainW-1:0] kp;
    logic [GainW-1:0] kd;
    logic [LimW-1:0]  limit;
  } axis_cfg_t;

  typedef struct packed {
    logic [PulseW-1:0] pmin;
    logic [PulseW-1:0] pmax;
  } pulse_cfg_t;

endpackage
`default_nettype wire

>>> hw/rtl/qrpd_axis_lane.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrpd_axis_lane
// One axis of the PD controller: error, two products, floor scale and clamp.
// ----------------------------------------------------------------------------
module qrpd_axis_lane (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 adv_i,
  input  wire                                 take_i,
  input  wire signed [qrpd_pkg::RateW-1:0]    target_i,
  input  wire signed [qrpd_pkg::RateW-1:0]    measured_i,
  input  qrpd_pkg::axis_cfg_t                 cfg_i,
  output logic signed [qrpd_pkg::CmdW-1:0]    cmd_o
);
  import qrpd_pkg::*;

  localparam int unsigned PpW  = ErrW + GainW + 1;
  localparam int unsigned PdW  = DiffW + GainW + 1;
  localparam int unsigned AccW = PdW + 1;
  localparam int unsigned ScW  = AccW - FracW;

  logic signed [ErrW-1:0]  prev_q;
  logic signed [ErrW-1:0]  err_d, err_q;
  logic signed [DiffW-1:0] diff_d, diff_q;
  logic signed [PpW-1:0]   pp_q;
  logic signed [PdW-1:0]   pd_q;
  logic signed [AccW-1:0]  acc;
  logic signed [ScW-1:0]   scaled, lim_pos, lim_neg;
  logic signed [CmdW-1:0]  cmd_d, cmd_q;

  assign err_d  = ErrW'(target_i) - ErrW'(measured_i);
  assign diff_d = DiffW'(err_d) - DiffW'(prev_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (take_i) begin
      prev_q <= err_d;
    end
  end

  // floor division by 4096 is an arithmetic shift
  assign acc     = AccW'(pp_q) + AccW'(pd_q);
  assign scaled  = ScW'(acc >>> FracW);
  assign lim_pos = $signed({{(ScW-LimW){1'b0}}, cfg_i.limit});
  assign lim_neg = -lim_pos;

  always_comb begin
    if (scaled > lim_pos) begin
      cmd_d = CmdW'(lim_pos);
    end else if (scaled < lim_neg) begin
      cmd_d = CmdW'(lim_neg);
    end else begin
      cmd_d = CmdW'(scaled);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      err_q  <= err_d;
      diff_q <= diff_d;
      pp_q   <= PpW'($signed({1'b0, cfg_i.kp}) * err_q);
      pd_q   <= PdW'($signed({1'b0, cfg_i.kd}) * diff_q);
      cmd_q  <= cmd_d;
    end
  end

  assign cmd_o = cmd_q;

endmodule
`default_nettype wire

>>> hw/rtl/qrpd_mixer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrpd_mixer
// X-frame mixer: combines throttle and the three axis commands, then clamps.
// ----------------------------------------------------------------------------
module qrpd_mixer (
  input  wire                                clk_i,
  input  wire                                adv_i,
  input  wire [qrpd_pkg::PulseW-1:0]         throttle_i,
  input  wire signed [qrpd_pkg::CmdW-1:0]    pitch_i,
  input  wire signed [qrpd_pkg::CmdW-1:0]    roll_i,
  input  wire signed [qrpd_pkg::CmdW-1:0]    yaw_i,
  input  qrpd_pkg::pulse_cfg_t               cfg_i,
  output qrpd_pkg::out_item_t                item_o
);
  import qrpd_pkg::*;

  localparam int unsigned MixW = PulseW + 2;

  logic signed [MixW-1:0] thr, cp, cr, cy, pmax, pmin;
  logic signed [MixW-1:0] mix [4];
  logic [PulseW-1:0]      pulse [4];
  out_item_t              item_q;

  function automatic logic [PulseW-1:0] clamp_pulse(
    input logic signed [MixW-1:0] p,
    input logic signed [MixW-1:0] hi,
    input logic signed [MixW-1:0] lo
  );
    logic signed [MixW-1:0] t;
    t = (p > hi) ? hi : p;
    t = (t < lo) ? lo : t;
    return t[PulseW-1:0];
  endfunction

  assign thr  = $signed({2'b00, throttle_i});
  assign cp   = MixW'(pitch_i);
  assign cr   = MixW'(roll_i);
  assign cy   = MixW'(yaw_i);
  assign pmax = $signed({2'b00, cfg_i.pmax});
  assign pmin = $signed({2'b00, cfg_i.pmin});

  assign mix[0] = thr + cp - cr + cy;
  assign mix[1] = thr - cp - cr - cy;
  assign mix[2] = thr - cp + cr + cy;
  assign mix[3] = thr + cp + cr - cy;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pulse[i] = clamp_pulse(mix[i], pmax, pmin);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_q.motor_front_pulse  <= pulse[0];
      item_q.motor_second_pulse <= pulse[1];
      item_q.motor_third_pulse  <= pulse[2];
      item_q.motor_fourth_pulse <= pulse[3];
    end
  end

  assign item_o = item_q;

endmodule
`default_nettype wire

>>> hw/rtl/quad_rate_pd_mixer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quad_rate_pd_mixer_core
// Rate PD controller for pitch, roll and yaw with an X-frame motor mixer.
// ----------------------------------------------------------------------------
//  channel  | signals                               | role
//  ---------+---------------------------------------+---------------------------
//  in       | in_valid_i, in_ready_o, in_item_i     | rates and throttle
//  out      | out_valid_o, out_ready_i, out_item_o  | four motor pulses
//  cfg      | cfg_we_i, cfg_idx_i, cfg_wdata_i      | gains, limits, write only
//
// One transfer per cycle while not stalled; stages are error, multiply,
// scale/clamp and mix. Three axis lanes run in parallel and feed the
// mixer stage. The whole pipeline advances together; it holds when the
// output register is full and out_ready_i is low. Reset clears valid
// bits, previous errors and loads the register defaults.
// ----------------------------------------------------------------------------
module quad_rate_pd_mixer_core (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  qrpd_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output qrpd_pkg::out_item_t                 out_item_o,
  input  wire                                 cfg_we_i,
  input  wire [qrpd_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  wire [qrpd_pkg::CfgDataW-1:0]        cfg_wdata_i
);
  import qrpd_pkg::*;

  logic [GainW-1:0]  kp_pr_q, kd_pr_q, kp_y_q, kd_y_q;
  logic [LimW-1:0]   limit_q;
  logic [PulseW-1:0] pmin_q, pmax_q;

  logic [PipeDepth-1:0] vld_q;
  logic                 adv, take;
  logic [PulseW-1:0]    thr_q [PipeDepth-1];
  logic signed [CmdW-1:0] cmd_p, cmd_r, cmd_y;
  axis_cfg_t  cfg_pr, cfg_y;
  pulse_cfg_t cfg_pulse;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_pr_q <= RstGainPPitchRoll;
      kd_pr_q <= RstGainDPitchRoll;
      kp_y_q  <= RstGainPYaw;
      kd_y_q  <= RstGainDYaw;
      limit_q <= RstAxisLimit;
      pmin_q  <= RstPulseMin;
      pmax_q  <= RstPulseMax;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgGainPPitchRoll: kp_pr_q <= cfg_wdata_i[GainW-1:0];
        CfgGainDPitchRoll: kd_pr_q <= cfg_wdata_i[GainW-1:0];
        CfgGainPYaw:       kp_y_q  <= cfg_wdata_i[GainW-1:0];
        CfgGainDYaw:       kd_y_q  <= cfg_wdata_i[GainW-1:0];
        CfgAxisLimit:      limit_q <= cfg_wdata_i[LimW-1:0];
        CfgPulseMin:       pmin_q  <= cfg_wdata_i[PulseW-1:0];
        CfgPulseMax:       pmax_q  <= cfg_wdata_i[PulseW-1:0];
        default: ;
      endcase
    end
  end

  assign adv         = !vld_q[PipeDepth-1] || out_ready_i;
  assign take        = in_valid_i && adv;
  assign in_ready_o  = adv;
  assign out_valid_o = vld_q[PipeDepth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PipeDepth-2:0], in_valid_i};
    end
  end

  // throttle rides alongside the lanes until the mixer
  always_ff @(posedge clk_i) begin
    if (adv) begin
      thr_q[0] <= in_item_i.throttle_pulse;
      for (int i = 1; i < PipeDepth - 1; i++) begin
        thr_q[i] <= thr_q[i-1];
      end
    end
  end

  assign cfg_pr    = '{kp: kp_pr_q, kd: kd_pr_q, limit: limit_q};
  assign cfg_y     = '{kp: kp_y_q,  kd: kd_y_q,  limit: limit_q};
  assign cfg_pulse = '{pmin: pmin_q, pmax: pmax_q};

  qrpd_axis_lane u_pitch (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .take_i     (take),
    .target_i   (in_item_i.pitch_rate_target),
    .measured_i (in_item_i.pitch_rate_measured),
    .cfg_i      (cfg_pr),
    .cmd_o      (cmd_p)
  );

  qrpd_axis_lane u_roll (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .take_i     (take),
    .target_i   (in_item_i.roll_rate_target),
    .measured_i (in_item_i.roll_rate_measured),
    .cfg_i      (cfg_pr),
    .cmd_o      (cmd_r)
  );

  qrpd_axis_lane u_yaw (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .take_i     (take),
    .target_i   (in_item_i.yaw_rate_target),
    .measured_i (in_item_i.yaw_rate_measured),
    .cfg_i      (cfg_y),
    .cmd_o      (cmd_y)
  );

  qrpd_mixer u_mixer (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .throttle_i (thr_q[PipeDepth-2]),
    .pitch_i    (cmd_p),
    .roll_i     (cmd_r),
    .yaw_i      (cmd_y),
    .cfg_i      (cfg_pulse),
    .item_o     (out_item_o)
  );

  a_ready_rule : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output stall");

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted transfer did not enter the pipeline");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline moved during a stall");

  a_pulse_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pmin_q <= pmax_q && $stable(pmin_q) && $stable(pmax_q))
      |-> (out_item_o.motor_front_pulse  <= pmax_q &&
           out_item_o.motor_front_pulse  >= pmin_q &&
           out_item_o.motor_fourth_pulse <= pmax_q &&
           out_item_o.motor_fourth_pulse >= pmin_q))
    else $error("motor pulse outside the configured range");

endmodule
`default_nettype wire
